FILE: hdl/tqa_pkg.sv
// tqa_pkg: shared types and constants for the thick quarter-arc generator
// no dependencies; used by tqa_ctrl, tqa_datapath and thick_quarter_arc_generator
package tqa_pkg;

    // field widths
    localparam int unsigned COORD_W  = 10;
    localparam int unsigned RADIUS_W = 6;
    localparam int unsigned COLOR_W  = 16;
    localparam int unsigned SPAN_W   = 12;
    localparam int unsigned STEP_W   = 7;
    localparam int unsigned DEC_W    = 10;
    localparam int unsigned COUNT_W  = 6;

    // recurrence constants
    localparam logic [COUNT_W-1:0] MAX_RESULTS = 6'd46;
    localparam logic signed [DEC_W-1:0] DEC_START     = 10'sd3;
    localparam logic signed [DEC_W-1:0] DEC_BIAS_MOVE = 10'sd6;
    localparam logic signed [DEC_W-1:0] DEC_BIAS_DIAG = 10'sd10;

    // arc command
    typedef struct packed {
        logic [COORD_W-1:0]  center_col;
        logic [COORD_W-1:0]  center_row;
        logic [RADIUS_W-1:0] radius;
        logic [COLOR_W-1:0]  color;
    } t_arc_cmd;

    // one pair of spans
    typedef struct packed {
        logic signed [SPAN_W-1:0] vert_col;
        logic signed [SPAN_W-1:0] vert_top_row;
        logic signed [SPAN_W-1:0] horiz_row;
        logic signed [SPAN_W-1:0] horiz_right_col;
        logic [COLOR_W-1:0]       pixel_color;
        logic                     last;
    } t_arc_span;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_tqa_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_step;
    } t_tqa_status;

endpackage

FILE: hdl/tqa_datapath.sv
// tqa_datapath: midpoint circle recurrence registers and span output register
// depends on tqa_pkg; driven by tqa_ctrl through t_tqa_cmd
module tqa_datapath (
    input  logic                i_clk,
    input  tqa_pkg::t_arc_cmd   i_cmd,
    input  tqa_pkg::t_tqa_cmd   i_ctl,
    output tqa_pkg::t_tqa_status o_status,
    output tqa_pkg::t_arc_span  o_span
);

    logic signed [tqa_pkg::STEP_W-1:0]  r_x, n_x;
    logic signed [tqa_pkg::STEP_W-1:0]  r_y, n_y;
    logic signed [tqa_pkg::DEC_W-1:0]   r_d, n_d;
    logic [tqa_pkg::COORD_W-1:0]        r_col;
    logic [tqa_pkg::COORD_W-1:0]        r_row;
    logic [tqa_pkg::COLOR_W-1:0]        r_color;
    logic [tqa_pkg::COUNT_W-1:0]        r_count, n_count;
    tqa_pkg::t_arc_span                 r_span, n_span;

    logic signed [tqa_pkg::DEC_W-1:0]   x_ext;
    logic signed [tqa_pkg::DEC_W-1:0]   y_ext;
    logic signed [tqa_pkg::DEC_W-1:0]   d_start;
    logic signed [tqa_pkg::SPAN_W-1:0]  x_span;
    logic signed [tqa_pkg::SPAN_W-1:0]  y_span;
    logic signed [tqa_pkg::SPAN_W-1:0]  col_span;
    logic signed [tqa_pkg::SPAN_W-1:0]  row_span;
    logic                               last_now;

    // sign extensions
    assign x_ext    = {{(tqa_pkg::DEC_W-tqa_pkg::STEP_W){r_x[tqa_pkg::STEP_W-1]}}, r_x};
    assign y_ext    = {{(tqa_pkg::DEC_W-tqa_pkg::STEP_W){r_y[tqa_pkg::STEP_W-1]}}, r_y};
    assign x_span   = {{(tqa_pkg::SPAN_W-tqa_pkg::STEP_W){r_x[tqa_pkg::STEP_W-1]}}, r_x};
    assign y_span   = {{(tqa_pkg::SPAN_W-tqa_pkg::STEP_W){r_y[tqa_pkg::STEP_W-1]}}, r_y};
    assign col_span = {{(tqa_pkg::SPAN_W-tqa_pkg::COORD_W){1'b0}}, r_col};
    assign row_span = {{(tqa_pkg::SPAN_W-tqa_pkg::COORD_W){1'b0}}, r_row};

    // starting decision 3 - 2r
    assign d_start = tqa_pkg::DEC_START
                   - {{(tqa_pkg::DEC_W-tqa_pkg::RADIUS_W-1){1'b0}}, i_cmd.radius, 1'b0};

    // one recurrence step
    always_comb begin
        n_x     = r_x + 7'sd1;
        n_count = r_count + 6'd1;
        if (r_d[tqa_pkg::DEC_W-1]) begin
            n_y = r_y;
            n_d = r_d + {x_ext[tqa_pkg::DEC_W-3:0], 2'b00} + tqa_pkg::DEC_BIAS_MOVE;
        end else begin
            n_y = r_y - 7'sd1;
            n_d = r_d + {x_ext[tqa_pkg::DEC_W-3:0] - y_ext[tqa_pkg::DEC_W-3:0], 2'b00}
                + tqa_pkg::DEC_BIAS_DIAG;
        end
        last_now = (n_x > n_y) || (n_count == tqa_pkg::MAX_RESULTS);
    end

    // span fields for the current point
    always_comb begin
        n_span                 = r_span;
        n_span.vert_col        = col_span + x_span;
        n_span.vert_top_row    = row_span - y_span;
        n_span.horiz_row       = row_span - x_span;
        n_span.horiz_right_col = col_span + y_span;
        n_span.pixel_color     = r_color;
        n_span.last            = last_now;
    end

    // recurrence state and command latch
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x     <= '0;
            r_y     <= {1'b0, i_cmd.radius};
            r_d     <= d_start;
            r_col   <= i_cmd.center_col;
            r_row   <= i_cmd.center_row;
            r_color <= i_cmd.color;
            r_count <= '0;
        end else if (i_ctl.step) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_d     <= n_d;
            r_count <= n_count;
        end
    end

    // output payload register, loaded once per step
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_span <= n_span;
        end
    end

    assign o_status.last_step = last_now;
    assign o_span             = r_span;

endmodule

FILE: hdl/tqa_ctrl.sv
// tqa_ctrl: idle/run sequencer and span valid register
// depends on tqa_pkg; commands tqa_datapath
module tqa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_stall,
    output logic                 o_span_valid,
    input  logic                 i_span_stall,
    input  tqa_pkg::t_tqa_status i_status,
    output tqa_pkg::t_tqa_cmd    o_ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state, n_state;
    logic r_valid, n_valid;
    logic out_free;

    // output register can take a new span this cycle
    assign out_free = !r_valid || !i_span_stall;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_ctl.load = 1'b0;
        o_ctl.step = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (out_free) begin
                    o_ctl.step = 1'b1;
                    if (i_status.last_step) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_valid = o_ctl.step || (r_valid && i_span_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_cmd_stall  = (r_state == S_RUN);
    assign o_span_valid = r_valid;

endmodule

FILE: hdl/thick_quarter_arc_generator.sv
// thick_quarter_arc_generator: top level, controller plus datapath
// depends on tqa_pkg, tqa_ctrl and tqa_datapath
//
// Takes one arc command (center, radius 0..63, color) and walks the integer
// midpoint circle recurrence over the upper-right octant pair, emitting one
// span pair per step while x <= y: a vertical span at column center_col+x
// starting at row center_row-y, and a horizontal span on row center_row-x
// ending at column center_col+y. The final span of an arc has last set; at
// most 46 spans are produced. A command is loaded in the idle state, and then
// one span is produced per cycle when the output is not stalled, with one
// recurrence step in the datapath per span. The command channel stalls while
// an arc is in progress; the next command is taken as soon as the last span
// is in the output register.
module thick_quarter_arc_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_stall,
    input  tqa_pkg::t_arc_cmd  i_cmd,
    output logic               o_span_valid,
    input  logic               i_span_stall,
    output tqa_pkg::t_arc_span o_span
);

    tqa_pkg::t_tqa_cmd    ctl;
    tqa_pkg::t_tqa_status status;

    // sequencer
    tqa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_cmd_valid),
        .o_cmd_stall  (o_cmd_stall),
        .o_span_valid (o_span_valid),
        .i_span_stall (i_span_stall),
        .i_status     (status),
        .o_ctl        (ctl)
    );

    // recurrence and span register
    tqa_datapath u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_status (status),
        .o_span   (o_span)
    );

    // a command transfer always starts an arc
    a_cmd_starts_arc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && !o_cmd_stall) |=> o_cmd_stall)
        else $error("command transfer did not start an arc");

    // a pending span that is not the final one means the arc is still running
    a_mid_span_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_span_valid && !o_span.last) |-> o_cmd_stall)
        else $error("command accepted before arc finished");

    // no span after reset
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_span_valid)
        else $error("span valid after reset");

endmodule
